### sv/mpf_pkg.sv
// Shared types and constants for the monochrome page frame buffer.
package mpf_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF = 8;
  localparam int HEAD_SLOTS = 3;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH = 8'h10;

  localparam logic [1:0] FUNC_SET = 2'd0;
  localparam logic [1:0] FUNC_CLR = 2'd1;
  localparam logic [1:0] FUNC_CLEAR_ALL = 2'd2;
  localparam logic [1:0] FUNC_REFRESH = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS
  } state_t;

  typedef struct packed {
    logic step;
    logic restart;
  } scan_ctl_t;

endpackage

### sv/mpf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/mpf_scan.sv
// Scan-out position counter and command byte formatting.
module mpf_scan #(
  parameter int COLUMNS = mpf_pkg::COLUMNS_DEF,
  parameter int PAGES = mpf_pkg::PAGES_DEF,
  localparam int AW = $clog2(COLUMNS * PAGES),
  localparam int PGW = (PAGES > 1) ? $clog2(PAGES) : 1,
  localparam int SW = $clog2(COLUMNS + mpf_pkg::HEAD_SLOTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  mpf_pkg::scan_ctl_t ctl,
  output logic [AW-1:0]     rd_addr,
  output logic              is_head,
  output logic [7:0]        cmd_byte,
  output logic              last
);

  logic [PGW-1:0] page, page_next;
  logic [SW-1:0]  slot, slot_next;
  logic           slot_end;

  assign slot_end = (slot == SW'(COLUMNS + mpf_pkg::HEAD_SLOTS - 1));
  assign is_head = (slot < SW'(mpf_pkg::HEAD_SLOTS));
  assign last = slot_end && (page == PGW'(PAGES - 1));
  assign rd_addr = AW'((32'(slot) - 32'(mpf_pkg::HEAD_SLOTS)) * 32'(PAGES) + 32'(page));

  always_comb begin
    if (slot == SW'(0)) begin
      cmd_byte = 8'(mpf_pkg::CMD_PAGE_BASE + 8'(page));
    end else if (slot == SW'(1)) begin
      cmd_byte = mpf_pkg::CMD_COL_LOW;
    end else begin
      cmd_byte = mpf_pkg::CMD_COL_HIGH;
    end
  end

  always_comb begin
    page_next = page;
    slot_next = slot;
    if (ctl.restart) begin
      page_next = '0;
      slot_next = '0;
    end else if (ctl.step) begin
      if (slot_end) begin
        slot_next = '0;
        page_next = (page == PGW'(PAGES - 1)) ? '0 : PGW'(page + PGW'(1));
      end else begin
        slot_next = SW'(slot + SW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page <= '0;
      slot <= '0;
    end else begin
      page <= page_next;
      slot <= slot_next;
    end
  end

endmodule

### sv/monochrome_page_framebuffer.sv
// Top level of the monochrome page frame buffer.
// Requests enter on start/func/px/py and are taken when start is high and busy
// is low. func selects set pixel, clear pixel, clear all, or refresh step.
// Set and clear pixel read the page byte and write it back; off-panel
// coordinates leave the store untouched. A set, clear or refresh request first
// reads the store, then modifies and writes back or emits the byte.
// A refresh step drives out_byte, is_data and frame_last for one cycle with
// valid high, in the cycle after the request is taken. The receiver cannot
// stall; every result is consumed when shown.
// Clear all and reset both run a clearing pass over the store, one entry a
// cycle across all COLUMNS*PAGES entries (1024 by default), with busy high;
// the scan restarts at page 0, first command byte.
// A new request is not taken until the previous one is through: busy stays high in the access state.
module monochrome_page_framebuffer #(
  parameter int COLUMNS = mpf_pkg::COLUMNS_DEF,
  parameter int PAGES = mpf_pkg::PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] func,
  input  logic [7:0] px,
  input  logic [7:0] py,
  output logic       valid,
  output logic [7:0] out_byte,
  output logic       is_data,
  output logic       frame_last
);

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW = $clog2(DEPTH);

  mpf_pkg::state_t    state, state_next;
  mpf_pkg::scan_ctl_t scan_ctl;

  logic [AW-1:0] clr_cnt;
  logic [1:0]    req_func;
  logic [AW-1:0] req_addr;
  logic [7:0]    req_mask;
  logic          req_hit;

  logic [AW-1:0] pix_addr;
  logic [7:0]    pix_mask;
  logic          pix_hit;
  logic          accept;
  logic          clr_done;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  logic [AW-1:0] scan_addr;
  logic          scan_head;
  logic [7:0]    scan_cmd;
  logic          scan_last;

  assign accept = start && !busy;
  assign clr_done = (clr_cnt == AW'(DEPTH - 1));
  assign pix_hit = (9'(px) < 9'(COLUMNS)) && (9'(py) < 9'(8 * PAGES));
  assign pix_addr = AW'(32'(px) * 32'(PAGES) + 32'(py[7:3]));
  assign pix_mask = 8'(8'd1 << py[2:0]);

  mpf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  mpf_scan #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctl     (scan_ctl),
    .rd_addr (scan_addr),
    .is_head (scan_head),
    .cmd_byte(scan_cmd),
    .last    (scan_last)
  );

  always_comb begin
    state_next = state;
    case (state)
      mpf_pkg::ST_CLEAR: begin
        if (clr_done) begin
          state_next = mpf_pkg::ST_IDLE;
        end
      end
      mpf_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (func == mpf_pkg::FUNC_CLEAR_ALL) ? mpf_pkg::ST_CLEAR
                                                          : mpf_pkg::ST_ACCESS;
        end
      end
      mpf_pkg::ST_ACCESS: begin
        state_next = mpf_pkg::ST_IDLE;
      end
      default: begin
        state_next = mpf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy = 1'b1;
    valid = 1'b0;
    we = 1'b0;
    waddr = req_addr;
    wdata = rdata | req_mask;
    raddr = pix_addr;
    scan_ctl = '0;
    case (state)
      mpf_pkg::ST_CLEAR: begin
        we = 1'b1;
        waddr = clr_cnt;
        wdata = '0;
      end
      mpf_pkg::ST_IDLE: begin
        busy = 1'b0;
        raddr = (func == mpf_pkg::FUNC_REFRESH) ? scan_addr : pix_addr;
        scan_ctl.restart = start && (func == mpf_pkg::FUNC_CLEAR_ALL);
      end
      mpf_pkg::ST_ACCESS: begin
        case (req_func)
          mpf_pkg::FUNC_SET: begin
            we = req_hit;
            wdata = rdata | req_mask;
          end
          mpf_pkg::FUNC_CLR: begin
            we = req_hit;
            wdata = rdata & ~req_mask;
          end
          mpf_pkg::FUNC_REFRESH: begin
            valid = 1'b1;
            scan_ctl.step = 1'b1;
          end
          default: begin
            we = 1'b0;
          end
        endcase
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign out_byte = scan_head ? scan_cmd : rdata;
  assign is_data = !scan_head;
  assign frame_last = scan_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpf_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == mpf_pkg::ST_CLEAR) begin
        clr_cnt <= clr_done ? '0 : AW'(clr_cnt + AW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func <= func;
      req_addr <= pix_addr;
      req_mask <= pix_mask;
      req_hit <= pix_hit;
    end
  end

endmodule

### tb/sv/monochrome_page_framebuffer_tb.sv
// Self-checking testbench for the page frame buffer: directed table, then random requests.
module monochrome_page_framebuffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOL = mpf_pkg::COLUMNS_DEF;
  localparam int NPAGE = mpf_pkg::PAGES_DEF;
  localparam int PAGE_SLOTS = mpf_pkg::HEAD_SLOTS + NCOL;
  localparam int RANDOM_ITEMS = 1350;
  localparam int DRAIN_CYCLES = 8;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] value;
    logic       data_flag;
    logic       last_flag;
  } scan_byte_t;

  typedef struct packed {
    logic [1:0] f;
    logic [7:0] x;
    logic [7:0] y;
    logic       typed;
    scan_byte_t want;
  } plan_row_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] func;
  logic [7:0] px;
  logic [7:0] py;
  logic       valid;
  logic [7:0] out_byte;
  logic       is_data;
  logic       frame_last;

  monochrome_page_framebuffer u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .px         (px),
    .py         (py),
    .valid      (valid),
    .out_byte   (out_byte),
    .is_data    (is_data),
    .frame_last (frame_last)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  logic [7:0] shadow_fb [NCOL*NPAGE];
  int         scan_pg;
  int         scan_sl;
  scan_byte_t pending_bytes [$];
  scan_byte_t head_byte;
  logic       typed_on;
  scan_byte_t typed_val;
  plan_row_t  plan [$];
  int         n_accepted;
  int         n_checked;
  int         n_errors;
  int         n_frames;
  int         n_clear_all;
  longint     cycles;

  function automatic void fb_reset();
    foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
    scan_pg = 0;
    scan_sl = 0;
  endfunction

  function automatic void model_request(input logic [1:0] f, input logic [7:0] x,
                                        input logic [7:0] y);
    int idx;
    scan_byte_t res;
    if (f == mpf_pkg::FUNC_SET || f == mpf_pkg::FUNC_CLR) begin
      if (x < NCOL && y < 8 * NPAGE) begin
        idx = x * NPAGE + y[7:3];
        shadow_fb[idx][y[2:0]] = (f == mpf_pkg::FUNC_SET);
      end
    end else if (f == mpf_pkg::FUNC_CLEAR_ALL) begin
      fb_reset();
      n_clear_all++;
    end else begin
      res.last_flag = 1'b0;
      if (scan_sl == 0) begin
        res.value = mpf_pkg::CMD_PAGE_BASE + 8'(scan_pg);
        res.data_flag = 1'b0;
      end else if (scan_sl == 1) begin
        res.value = mpf_pkg::CMD_COL_LOW;
        res.data_flag = 1'b0;
      end else if (scan_sl == 2) begin
        res.value = mpf_pkg::CMD_COL_HIGH;
        res.data_flag = 1'b0;
      end else begin
        res.value = shadow_fb[(scan_sl - mpf_pkg::HEAD_SLOTS) * NPAGE + scan_pg];
        res.data_flag = 1'b1;
        res.last_flag = (scan_sl == PAGE_SLOTS - 1 && scan_pg == NPAGE - 1);
      end
      if (res.last_flag) n_frames++;
      scan_sl++;
      if (scan_sl >= PAGE_SLOTS) begin
        scan_sl = 0;
        scan_pg = (scan_pg + 1) % NPAGE;
      end
      pending_bytes.push_back(typed_on ? typed_val : res);
    end
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else if (!rst) begin
      if (valid) begin
        if (pending_bytes.size() == 0) begin
          $error("unexpected result: out_byte=%h is_data=%b frame_last=%b",
                 out_byte, is_data, frame_last);
          n_errors++;
        end else begin
          head_byte = pending_bytes.pop_front();
          n_checked++;
          if (out_byte !== head_byte.value) begin
            $error("out_byte: expected %h, got %h", head_byte.value, out_byte);
            n_errors++;
          end
          if (is_data !== head_byte.data_flag) begin
            $error("is_data: expected %b, got %b", head_byte.data_flag, is_data);
            n_errors++;
          end
          if (frame_last !== head_byte.last_flag) begin
            $error("frame_last: expected %b, got %b", head_byte.last_flag, frame_last);
            n_errors++;
          end
        end
      end
      if (start && !busy) begin
        n_accepted++;
        model_request(func, px, py);
      end
    end
  end

  function automatic void add_row(input logic [1:0] f, input logic [7:0] x, input logic [7:0] y,
                                  input logic typed, input logic [7:0] v, input logic d);
    plan_row_t row;
    row.f = f;
    row.x = x;
    row.y = y;
    row.typed = typed;
    row.want.value = v;
    row.want.data_flag = d;
    row.want.last_flag = 1'b0;
    plan.push_back(row);
  endfunction

  task automatic issue(input logic [1:0] f, input logic [7:0] x, input logic [7:0] y);
    int seen;
    seen = n_accepted;
    func = f;
    px = x;
    py = y;
    start = 1'b1;
    do @(negedge clk); while (n_accepted == seen);
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      start = 1'b0;
      repeat (n) begin
        func = 2'($urandom);
        px = 8'($urandom);
        py = 8'($urandom);
        @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int r;
    int col;
    int n_sent;
    bit burst;
    logic [1:0] f;
    logic [7:0] x;
    logic [7:0] y;
    rst = 1'b1;
    start = 1'b0;
    func = mpf_pkg::FUNC_SET;
    px = 8'h00;
    py = 8'h00;
    typed_on = 1'b0;
    typed_val = '0;
    n_accepted = 0;
    n_checked = 0;
    n_errors = 0;
    n_frames = 0;
    n_clear_all = 0;
    cycles = 0;
    n_sent = 0;
    burst = 1'b0;
    fb_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_row(mpf_pkg::FUNC_REFRESH,   8'd0,   8'd0,   1'b1, mpf_pkg::CMD_PAGE_BASE, 1'b0);
    add_row(mpf_pkg::FUNC_REFRESH,   8'd0,   8'd0,   1'b1, mpf_pkg::CMD_COL_LOW,   1'b0);
    add_row(mpf_pkg::FUNC_REFRESH,   8'd0,   8'd0,   1'b1, mpf_pkg::CMD_COL_HIGH,  1'b0);
    add_row(mpf_pkg::FUNC_REFRESH,   8'd0,   8'd0,   1'b1, 8'h00,                  1'b1);
    add_row(mpf_pkg::FUNC_SET,       8'd0,   8'd0,   1'b0, 8'h00,                  1'b0);
    add_row(mpf_pkg::FUNC_SET,       8'd127, 8'd63,  1'b0, 8'h00,                  1'b0);
    add_row(mpf_pkg::FUNC_SET,       8'd128, 8'd0,   1'b0, 8'h00,                  1'b0);
    add_row(mpf_pkg::FUNC_SET,       8'd0,   8'd64,  1'b0, 8'h00,                  1'b0);
    add_row(mpf_pkg::FUNC_SET,       8'd255, 8'd255, 1'b0, 8'h00,                  1'b0);
    add_row(mpf_pkg::FUNC_CLR,       8'd255, 8'd255, 1'b0, 8'h00,                  1'b0);
    add_row(mpf_pkg::FUNC_SET,       8'd1,   8'd0,   1'b0, 8'h00,                  1'b0);
    add_row(mpf_pkg::FUNC_REFRESH,   8'd0,   8'd0,   1'b1, 8'h01,                  1'b1);
    add_row(mpf_pkg::FUNC_SET,       8'd2,   8'd7,   1'b0, 8'h00,                  1'b0);
    add_row(mpf_pkg::FUNC_SET,       8'd2,   8'd6,   1'b0, 8'h00,                  1'b0);
    add_row(mpf_pkg::FUNC_CLR,       8'd2,   8'd6,   1'b0, 8'h00,                  1'b0);
    add_row(mpf_pkg::FUNC_REFRESH,   8'd0,   8'd0,   1'b1, 8'h80,                  1'b1);
    add_row(mpf_pkg::FUNC_SET,       8'd3,   8'd1,   1'b0, 8'h00,                  1'b0);
    add_row(mpf_pkg::FUNC_SET,       8'd3,   8'd3,   1'b0, 8'h00,                  1'b0);
    add_row(mpf_pkg::FUNC_REFRESH,   8'd170, 8'd85,  1'b0, 8'h00,                  1'b0);
    add_row(mpf_pkg::FUNC_CLEAR_ALL, 8'd85,  8'd170, 1'b0, 8'h00,                  1'b0);
    add_row(mpf_pkg::FUNC_REFRESH,   8'd0,   8'd0,   1'b1, mpf_pkg::CMD_PAGE_BASE, 1'b0);
    add_row(mpf_pkg::FUNC_SET,       8'd64,  8'd32,  1'b0, 8'h00,                  1'b0);
    add_row(mpf_pkg::FUNC_REFRESH,   8'd255, 8'd255, 1'b1, mpf_pkg::CMD_COL_LOW,   1'b0);
    add_row(mpf_pkg::FUNC_REFRESH,   8'd0,   8'd0,   1'b1, mpf_pkg::CMD_COL_HIGH,  1'b0);
    add_row(mpf_pkg::FUNC_REFRESH,   8'd0,   8'd0,   1'b1, 8'h00,                  1'b1);

    foreach (plan[i]) begin
      typed_on = plan[i].typed;
      typed_val = plan[i].want;
      issue(plan[i].f, plan[i].x, plan[i].y);
      hold_off(pick_gap());
    end
    typed_on = 1'b0;
    drain();

    while (n_sent < RANDOM_ITEMS || n_frames == 0) begin
      if (n_sent % 200 == 199) burst = ($urandom_range(0, 2) == 0);
      if (n_sent == RANDOM_ITEMS / 2) drain();
      r = $urandom_range(0, 99);
      if (r < 78) f = mpf_pkg::FUNC_REFRESH;
      else if (r < 91) f = mpf_pkg::FUNC_SET;
      else if (r < 98) f = mpf_pkg::FUNC_CLR;
      else f = (n_frames > 0) ? mpf_pkg::FUNC_CLEAR_ALL : mpf_pkg::FUNC_REFRESH;
      x = 8'($urandom);
      y = 8'($urandom);
      if (f == mpf_pkg::FUNC_SET || f == mpf_pkg::FUNC_CLR) begin
        r = $urandom_range(0, 9);
        if (r < 4) begin
          col = (scan_sl >= mpf_pkg::HEAD_SLOTS) ? scan_sl - mpf_pkg::HEAD_SLOTS : 0;
          x = 8'(col + $urandom_range(0, 12));
          y = 8'(scan_pg * 8 + $urandom_range(0, 7));
        end else if (r < 8) begin
          x = 8'($urandom_range(0, NCOL - 1));
          y = 8'($urandom_range(0, 8 * NPAGE - 1));
        end
      end
      issue(f, x, y);
      n_sent++;
      hold_off(burst ? 0 : pick_gap());
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d requests, %0d scan bytes checked", n_accepted, n_checked);
    $display("frame wraps %0d, clear-all passes %0d", n_frames, n_clear_all);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
